// ===== design/arq_pkg.sv =====
// Shared types and constants for the retransmit acknowledge queue.
// Used by arq_slot_eval, the top module and the testbench; depends on nothing.
package arq_pkg;

   localparam logic [27:0] DAY_MS = 28'd86400000;

   typedef enum logic [1:0] {
      MODE_ENQUEUE = 2'd0,
      MODE_CONFIRM = 2'd1,
      MODE_SCAN    = 2'd2,
      MODE_NONE    = 2'd3
   } mode_type;

   localparam logic [1:0] KIND_DATA = 2'd0;
   localparam logic [1:0] KIND_FWD  = 2'd1;
   localparam logic [1:0] KIND_CONF = 2'd2;

   typedef enum logic [2:0] {
      OC_ACCEPTED   = 3'd0,
      OC_FULL       = 3'd1,
      OC_FIRST_SEND = 3'd2,
      OC_RESEND     = 3'd3,
      OC_SENT_ONCE  = 3'd4,
      OC_DELIVERED  = 3'd5,
      OC_GAVE_UP    = 3'd6
   } outcome_type;

   localparam logic CSR_MAX_ATTEMPTS = 1'b0;
   localparam logic CSR_TIMEOUT_MS   = 1'b1;

   typedef struct packed {
      logic [1:0]  mode;
      logic [7:0]  packet_tag;
      logic [7:0]  dest_id;
      logic [15:0] msg_id;
      logic [1:0]  pkt_kind;
      logic [26:0] now_ms;
   } req_type;

   typedef struct packed {
      logic [2:0]  outcome;
      logic [7:0]  out_tag;
      logic [7:0]  out_dest;
      logic [15:0] out_msg;
      logic [3:0]  attempt_number;
      logic        last;
   } rsp_type;

   typedef struct packed {
      logic [7:0]  dest;
      logic [15:0] msg;
      logic [1:0]  kind;
      logic [7:0]  tag;
      logic [3:0]  attempts;
      logic [26:0] stamp;
      logic        delivered;
   } entry_type;

   typedef struct packed {
      logic        emit;
      logic        keep;
      outcome_type outcome;
      logic [3:0]  attempt;
   } dec_type;

endpackage

// ===== design/arq_ram.sv =====
// Generic single-write, single-read RAM with registered, enabled read.
// No dependencies.
module arq_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic                     re,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;
endmodule

// ===== design/arq_slot_eval.sv =====
// Per-entry decision for confirm and scan walks: new entry value and result.
// Depends on arq_pkg.
module arq_slot_eval
   import arq_pkg::*;
(
   input  entry_type   entry_in,
   input  logic        is_scan,
   input  req_type     req,
   input  logic [3:0]  max_attempts,
   input  logic [15:0] timeout_ms,
   output entry_type   entry_out,
   output dec_type     dec
);
   logic [27:0] now_w;
   logic [27:0] stamp_w;
   logic [27:0] elapsed;

   assign now_w   = {1'b0, req.now_ms};
   assign stamp_w = {1'b0, entry_in.stamp};
   assign elapsed = (now_w >= stamp_w) ? (now_w - stamp_w) : (DAY_MS - stamp_w + now_w);

   always_comb begin
      entry_out   = entry_in;
      dec.emit    = 1'b0;
      dec.keep    = 1'b1;
      dec.outcome = OC_ACCEPTED;
      dec.attempt = entry_in.attempts;
      if (!is_scan) begin
         if (entry_in.dest == req.dest_id && entry_in.msg == req.msg_id) begin
            entry_out.delivered = 1'b1;
         end
      end else if (entry_in.delivered) begin
         dec.emit    = 1'b1;
         dec.keep    = 1'b0;
         dec.outcome = OC_DELIVERED;
      end else if (entry_in.kind == KIND_FWD || entry_in.kind == KIND_CONF) begin
         dec.emit    = 1'b1;
         dec.keep    = 1'b0;
         dec.outcome = OC_SENT_ONCE;
         dec.attempt = 4'd1;
      end else if (entry_in.attempts == 4'd0) begin
         entry_out.attempts = 4'd1;
         entry_out.stamp    = req.now_ms;
         dec.emit    = 1'b1;
         dec.outcome = OC_FIRST_SEND;
         dec.attempt = 4'd1;
      end else if (elapsed > {12'd0, timeout_ms}) begin
         dec.emit = 1'b1;
         if (entry_in.attempts >= max_attempts) begin
            dec.keep    = 1'b0;
            dec.outcome = OC_GAVE_UP;
         end else begin
            if (entry_in.attempts != 4'd15) begin
               entry_out.attempts = entry_in.attempts + 4'd1;
            end
            entry_out.stamp = req.now_ms;
            dec.outcome = OC_RESEND;
            dec.attempt = entry_out.attempts;
         end
      end
   end
endmodule

// ===== design/retransmit_ack_queue_top.sv =====
// Retransmit acknowledge queue: entries in one RAM, walked in order.
// Depends on arq_pkg, arq_ram and arq_slot_eval.
//
//  channel  ports                              role
//  req      req_valid/req_ready/req_payload    enqueue, confirm or scan transaction
//  rsp      rsp_valid/rsp_ready/rsp_payload    result transactions, last flags the end
//  csr      csr_we/csr_index/csr_wdata         max_attempts, timeout_ms
//
// Enqueue writes the RAM straight from idle; confirm and scan walk the entries, one
// RAM read per entry and one write-back per kept entry through the single memory port pair.
// One result is held back so the final one can carry last.
// A scan stalls while a result waits and the output register is occupied and not being taken.
// Synchronous reset empties the queue; RAM contents are not cleared.
module retransmit_ack_queue_top
   import arq_pkg::*;
#(
   parameter int QUEUE_DEPTH = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  req_type     req_payload,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output rsp_type     rsp_payload,
   input  logic        csr_we,
   input  logic        csr_index,
   input  logic [15:0] csr_wdata
);
   localparam int AW = $clog2(QUEUE_DEPTH);
   localparam int CW = $clog2(QUEUE_DEPTH + 1);

   typedef enum logic [1:0] {ST_IDLE, ST_WALK, ST_FLUSH} state_type;

   state_type       state_ff, state_in;
   req_type         req_ff, req_in;
   logic [CW-1:0]   count_ff, count_in;
   logic [CW-1:0]   rd_idx_ff, rd_idx_in;
   logic [CW-1:0]   proc_idx_ff, proc_idx_in;
   logic [CW-1:0]   wr_ff, wr_in;
   logic            proc_valid_ff, proc_valid_in;
   rsp_type         hold_ff, hold_in;
   logic            hold_valid_ff, hold_valid_in;
   rsp_type         out_ff, out_in;
   logic            out_valid_ff, out_valid_in;
   logic [3:0]      max_att_ff;
   logic [15:0]     timeout_ff;

   logic            ram_we, ram_re;
   logic [AW-1:0]   ram_waddr, ram_raddr;
   entry_type       ram_wdata, ram_rdata, eval_entry;
   dec_type         dec;
   logic            out_free, stall, is_scan;

   arq_ram #(.WIDTH($bits(entry_type)), .DEPTH(QUEUE_DEPTH)) u_ram (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .re    (ram_re),
      .raddr (ram_raddr),
      .rdata (ram_rdata)
   );

   assign is_scan = (req_ff.mode == MODE_SCAN);

   arq_slot_eval u_eval (
      .entry_in     (ram_rdata),
      .is_scan      (is_scan),
      .req          (req_ff),
      .max_attempts (max_att_ff),
      .timeout_ms   (timeout_ff),
      .entry_out    (eval_entry),
      .dec          (dec)
   );

   assign out_free  = !out_valid_ff || rsp_ready;
   assign stall     = proc_valid_ff && dec.emit && hold_valid_ff && !out_free;
   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid   = out_valid_ff;
   assign rsp_payload = out_ff;

   always_comb begin
      state_in      = state_ff;
      req_in        = req_ff;
      count_in      = count_ff;
      rd_idx_in     = rd_idx_ff;
      proc_idx_in   = proc_idx_ff;
      wr_in         = wr_ff;
      proc_valid_in = proc_valid_ff;
      hold_in       = hold_ff;
      hold_valid_in = hold_valid_ff;
      out_in        = out_ff;
      out_valid_in  = out_valid_ff && !rsp_ready;
      ram_we        = 1'b0;
      ram_waddr     = wr_ff[AW-1:0];
      ram_wdata     = eval_entry;
      ram_re        = 1'b0;
      ram_raddr     = rd_idx_ff[AW-1:0];

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               req_in = req_payload;
               hold_in.out_tag        = req_payload.packet_tag;
               hold_in.out_dest       = req_payload.dest_id;
               hold_in.out_msg        = req_payload.msg_id;
               hold_in.attempt_number = 4'd0;
               hold_in.last           = 1'b0;
               wr_in    = '0;
               state_in = ST_FLUSH;
               if (req_payload.mode == MODE_ENQUEUE) begin
                  hold_valid_in = 1'b1;
                  if (count_ff == CW'(QUEUE_DEPTH)) begin
                     hold_in.outcome = OC_FULL;
                  end else begin
                     hold_in.outcome = OC_ACCEPTED;
                     ram_we    = 1'b1;
                     ram_waddr = count_ff[AW-1:0];
                     ram_wdata = '{dest: req_payload.dest_id, msg: req_payload.msg_id,
                                   kind: req_payload.pkt_kind, tag: req_payload.packet_tag,
                                   attempts: 4'd0, stamp: 27'd0, delivered: 1'b0};
                     count_in  = count_ff + CW'(1);
                  end
               end else if ((req_payload.mode == MODE_CONFIRM ||
                             req_payload.mode == MODE_SCAN) && count_ff != '0) begin
                  ram_re        = 1'b1;
                  ram_raddr     = '0;
                  rd_idx_in     = CW'(1);
                  proc_idx_in   = '0;
                  proc_valid_in = 1'b1;
                  state_in      = ST_WALK;
               end
            end
         end
         ST_WALK: begin
            if (!stall) begin
               if (proc_valid_ff) begin
                  if (dec.keep) begin
                     ram_we = 1'b1;
                     wr_in  = wr_ff + CW'(1);
                  end
                  if (dec.emit) begin
                     if (hold_valid_ff) begin
                        out_in       = hold_ff;
                        out_valid_in = 1'b1;
                     end
                     hold_valid_in          = 1'b1;
                     hold_in.outcome        = dec.outcome;
                     hold_in.out_tag        = ram_rdata.tag;
                     hold_in.out_dest       = ram_rdata.dest;
                     hold_in.out_msg        = ram_rdata.msg;
                     hold_in.attempt_number = dec.attempt;
                     hold_in.last           = 1'b0;
                  end
               end
               if (rd_idx_ff < count_ff) begin
                  ram_re        = 1'b1;
                  rd_idx_in     = rd_idx_ff + CW'(1);
                  proc_idx_in   = rd_idx_ff;
                  proc_valid_in = 1'b1;
               end else begin
                  proc_valid_in = 1'b0;
                  if (!proc_valid_ff) begin
                     count_in = wr_ff;
                     state_in = ST_FLUSH;
                  end
               end
            end
         end
         ST_FLUSH: begin
            if (!hold_valid_ff) begin
               state_in = ST_IDLE;
            end else if (out_free) begin
               out_in        = hold_ff;
               out_in.last   = 1'b1;
               out_valid_in  = 1'b1;
               hold_valid_in = 1'b0;
               state_in      = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         count_ff      <= '0;
         rd_idx_ff     <= '0;
         proc_idx_ff   <= '0;
         wr_ff         <= '0;
         proc_valid_ff <= 1'b0;
         hold_valid_ff <= 1'b0;
         out_valid_ff  <= 1'b0;
         max_att_ff    <= 4'd3;
         timeout_ff    <= 16'd1000;
      end else begin
         state_ff      <= state_in;
         count_ff      <= count_in;
         rd_idx_ff     <= rd_idx_in;
         proc_idx_ff   <= proc_idx_in;
         wr_ff         <= wr_in;
         proc_valid_ff <= proc_valid_in;
         hold_valid_ff <= hold_valid_in;
         out_valid_ff  <= out_valid_in;
         if (csr_we) begin
            unique case (csr_index)
               CSR_MAX_ATTEMPTS: max_att_ff <= csr_wdata[3:0];
               CSR_TIMEOUT_MS:   timeout_ff <= csr_wdata;
               default:          ;
            endcase
         end
      end
      req_ff  <= req_in;
      hold_ff <= hold_in;
      out_ff  <= out_in;
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(QUEUE_DEPTH))
      else $error("entry count beyond queue depth");

   a_idle_no_hold: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_IDLE |-> !hold_valid_ff)
      else $error("held result left behind at idle");

   a_wr_behind_rd: assert property (@(posedge clock) disable iff (reset)
      proc_valid_ff |-> (wr_ff <= proc_idx_ff && proc_idx_ff < rd_idx_ff))
      else $error("write-back pointer overtook read pointer");

   a_last_then_idle: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_FLUSH && hold_valid_ff && out_free) |=> rsp_valid && rsp_payload.last)
      else $error("final result not presented with last");
endmodule

// ===== sim/tb.sv =====
// Self-checking testbench for retransmit_ack_queue_top: enqueue, confirm and scan traffic.
// A scoreboard class predicts the result transactions of the queue. Depends on arq_pkg.
`timescale 1ns / 1ps

module tb;
   import arq_pkg::*;

   localparam int DEPTH = 16;

   class arq_scoreboard;
      rsp_type     pending[$];
      int          errors;
      logic [3:0]  lim_attempts;
      logic [15:0] lim_timeout;
      entry_type   q[$];

      function new();
         errors = 0;
         lim_attempts = 4'd3;
         lim_timeout = 16'd1000;
      endfunction

      function void set_reg(logic idx, logic [15:0] v);
         if (idx == CSR_MAX_ATTEMPTS) lim_attempts = v[3:0];
         else lim_timeout = v;
      endfunction

      function void push_rsp(outcome_type oc, entry_type e, logic [3:0] att);
         rsp_type r;
         r.outcome = oc;
         r.out_tag = e.tag;
         r.out_dest = e.dest;
         r.out_msg = e.msg;
         r.attempt_number = att;
         r.last = 1'b0;
         pending.push_back(r);
      endfunction

      function void note_req(req_type t);
         entry_type e;
         entry_type kept[$];
         logic [27:0] el;
         int n0;
         e = '0;
         e.dest = t.dest_id;
         e.msg = t.msg_id;
         e.kind = t.pkt_kind;
         e.tag = t.packet_tag;
         n0 = pending.size();
         case (t.mode)
            MODE_ENQUEUE: begin
               if (q.size() >= DEPTH) push_rsp(OC_FULL, e, 4'd0);
               else begin
                  q.push_back(e);
                  push_rsp(OC_ACCEPTED, e, 4'd0);
               end
            end
            MODE_CONFIRM: begin
               foreach (q[i])
                  if (q[i].dest == t.dest_id && q[i].msg == t.msg_id) q[i].delivered = 1'b1;
            end
            MODE_SCAN: begin
               foreach (q[i]) begin
                  e = q[i];
                  if (e.delivered) push_rsp(OC_DELIVERED, e, e.attempts);
                  else if (e.kind == KIND_FWD || e.kind == KIND_CONF)
                     push_rsp(OC_SENT_ONCE, e, 4'd1);
                  else if (e.attempts == 0) begin
                     e.attempts = 4'd1;
                     e.stamp = t.now_ms;
                     push_rsp(OC_FIRST_SEND, e, 4'd1);
                     kept.push_back(e);
                  end else begin
                     if (t.now_ms >= e.stamp) el = {1'b0, t.now_ms} - {1'b0, e.stamp};
                     else el = {1'b0, t.now_ms} + DAY_MS - {1'b0, e.stamp};
                     if (el > lim_timeout) begin
                        if (e.attempts >= lim_attempts)
                           push_rsp(OC_GAVE_UP, e, e.attempts);
                        else begin
                           if (e.attempts < 15) e.attempts++;
                           e.stamp = t.now_ms;
                           push_rsp(OC_RESEND, e, e.attempts);
                           kept.push_back(e);
                        end
                     end else kept.push_back(e);
                  end
               end
               q = kept;
            end
            default: ;
         endcase
         if (pending.size() > n0) pending[pending.size() - 1].last = 1'b1;
      endfunction

      function void check_rsp(rsp_type got);
         rsp_type want;
         if (pending.size() == 0) begin
            $display("%0t: unexpected result %p", $time, got);
            errors++;
            return;
         end
         want = pending.pop_front();
         if (got.outcome !== want.outcome)
            $display("%0t: outcome exp %0d got %0d", $time, want.outcome, got.outcome);
         if (got.out_tag !== want.out_tag)
            $display("%0t: out_tag exp %0h got %0h", $time, want.out_tag, got.out_tag);
         if (got.out_dest !== want.out_dest)
            $display("%0t: out_dest exp %0h got %0h", $time, want.out_dest, got.out_dest);
         if (got.out_msg !== want.out_msg)
            $display("%0t: out_msg exp %0h got %0h", $time, want.out_msg, got.out_msg);
         if (got.attempt_number !== want.attempt_number)
            $display("%0t: attempt_number exp %0d got %0d", $time, want.attempt_number,
                     got.attempt_number);
         if (got.last !== want.last)
            $display("%0t: last exp %0b got %0b", $time, want.last, got.last);
         if (got !== want) errors++;
      endfunction
   endclass

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   req_type     req_payload = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   rsp_type     rsp_payload;
   logic        csr_we = 1'b0;
   logic        csr_index = 1'b0;
   logic [15:0] csr_wdata = '0;

   arq_scoreboard sb = new();
   bit          calm = 1'b0;
   logic [26:0] clock_ms = '0;
   logic [7:0]  dests[4] = '{8'h00, 8'hFF, 8'h5A, 8'hA5};
   logic [15:0] msgs[4] = '{16'h0000, 16'hFFFF, 16'h1234, 16'hEDCB};

   retransmit_ack_queue_top #(.QUEUE_DEPTH(DEPTH)) u_top (.*);

   always #4 clock = ~clock;

   always @(posedge clock)
      if (!reset && rsp_valid && rsp_ready) sb.check_rsp(rsp_payload);

   always @(negedge clock)
      rsp_ready <= calm || ($urandom_range(99) >= 35);

   task automatic send(req_type t);
      @(negedge clock);
      while (!calm && $urandom_range(99) < 35) @(negedge clock);
      req_valid <= 1'b1;
      req_payload <= t;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      sb.note_req(t);
      @(negedge clock);
      req_valid <= 1'b0;
   endtask

   task automatic drain();
      int guard;
      guard = 0;
      while (sb.pending.size() != 0 && guard < 200000) begin
         @(posedge clock);
         guard++;
      end
      repeat (3 * DEPTH + 10) @(posedge clock);
   endtask

   task automatic write_reg(logic idx, logic [15:0] v);
      drain();
      @(negedge clock);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= v;
      @(negedge clock);
      csr_we <= 1'b0;
      sb.set_reg(idx, v);
   endtask

   function automatic req_type mk(mode_type m, logic [7:0] tg, logic [7:0] d, logic [15:0] ms,
                                  logic [1:0] k, logic [26:0] nw);
      req_type t;
      t.mode = m;
      t.packet_tag = tg;
      t.dest_id = d;
      t.msg_id = ms;
      t.pkt_kind = k;
      t.now_ms = nw;
      return t;
   endfunction

   function automatic req_type rnd_item();
      int p;
      logic [63:0] raw;
      p = $urandom_range(99);
      clock_ms = 27'((clock_ms + $urandom_range(1500)) % 86400000);
      raw = {$urandom, $urandom};
      if (p < 5) return req_type'(raw[62:0]);
      if (p < 45)
         return mk(MODE_ENQUEUE, 8'($urandom), dests[$urandom_range(3)],
                   msgs[$urandom_range(3)], 2'($urandom_range(3)), 27'($urandom));
      if (p < 60)
         return mk(MODE_CONFIRM, 8'($urandom), dests[$urandom_range(3)],
                   msgs[$urandom_range(3)], 2'($urandom_range(3)), 27'($urandom));
      if (p < 63)
         return mk(MODE_NONE, 8'($urandom), 8'($urandom), 16'($urandom), 2'($urandom),
                   27'($urandom));
      return mk(MODE_SCAN, 8'($urandom), 8'($urandom), 16'($urandom), 2'($urandom),
                clock_ms);
   endfunction

   initial begin
      #2000000;
      $display("tb: FAIL");
      $finish;
   end

   initial begin
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed: fill to full, all kinds, midnight wrap, confirm, ignored mode
      for (int i = 0; i < 17; i++)
         send(mk(MODE_ENQUEUE, 8'(i * 15), dests[i % 4], msgs[i % 4], 2'(i % 4), 27'h7FFFFFF));
      send(mk(MODE_CONFIRM, 8'hFF, dests[1], msgs[1], 2'd3, '0));
      send(mk(MODE_NONE, 8'hFF, 8'hFF, 16'hFFFF, 2'd3, 27'h7FFFFFF));
      send(mk(MODE_SCAN, '0, '0, '0, '0, 27'd86399000));
      send(mk(MODE_SCAN, '0, '0, '0, '0, 27'd86399999));
      send(mk(MODE_SCAN, '0, '0, '0, '0, 27'd1500));
      send(mk(MODE_SCAN, '0, '0, '0, '0, 27'd3000));
      send(mk(MODE_SCAN, '0, '0, '0, '0, 27'd5000));
      send(mk(MODE_SCAN, '0, '0, '0, '0, 27'd7000));

      write_reg(CSR_MAX_ATTEMPTS, 16'd0);
      write_reg(CSR_TIMEOUT_MS, 16'd0);
      for (int i = 0; i < 4; i++)
         send(mk(MODE_ENQUEUE, 8'(i), dests[i], msgs[i], KIND_DATA, '0));
      send(mk(MODE_SCAN, '0, '0, '0, '0, 27'd10));
      send(mk(MODE_SCAN, '0, '0, '0, '0, 27'd10));
      send(mk(MODE_SCAN, '0, '0, '0, '0, 27'd11));

      for (int ph = 0; ph < 4; ph++) begin
         case (ph)
            0: begin
               write_reg(CSR_MAX_ATTEMPTS, 16'd15);
               write_reg(CSR_TIMEOUT_MS, 16'd200);
            end
            1: begin
               write_reg(CSR_MAX_ATTEMPTS, 16'hFFF1);
               write_reg(CSR_TIMEOUT_MS, 16'hFFFF);
            end
            2: write_reg(CSR_TIMEOUT_MS, 16'd700);
            default: write_reg(CSR_MAX_ATTEMPTS, 16'd3);
         endcase
         calm = (ph == 2);
         for (int i = 0; i < 57; i++) begin
            send(rnd_item());
            if (ph == 1 && i == 30) drain();
         end
         calm = 1'b0;
      end

      drain();
      if (sb.pending.size() != 0) sb.errors++;
      if (sb.errors == 0) $display("tb: PASS");
      else $display("tb: FAIL");
      $finish;
   end

endmodule
